FILE: rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master bit engine: request codes,
// sequencer phases, engine state and the request and result payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // Command codes carried in req_type
  localparam logic [2:0] REQ_START = 3'd0;
  localparam logic [2:0] REQ_STOP  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_WAIT  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [7:0] TICKS_PER_US_RST = 8'd16;
  localparam logic [7:0] ACK_TIMEOUT_RST  = 8'd250;

  // Bits in one byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_SP_C    = 5'd5,
    PH_WR_SET  = 5'd6,
    PH_WR_HI   = 5'd7,
    PH_WR_LO   = 5'd8,
    PH_WA_REL  = 5'd9,
    PH_WA_HI   = 5'd10,
    PH_WA_POLL = 5'd11,
    PH_RD_LO   = 5'd12,
    PH_RD_HI   = 5'd13,
    PH_AK_SET  = 5'd14,
    PH_AK_HI   = 5'd15
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [9:0]  delay_count;
    logic [7:0]  poll_count;
    logic        scl;
    logic        sda;
    logic        sda_drive;
    logic        error_flag;
    logic        ack_latch;
    logic [7:0]  rx;
  } eng_state_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [2:0]  req_type;
    logic [7:0]  tx_byte;
    logic        send_ack;
    logic        sda_level;
  } req_t;

  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  rx_byte;
    logic        ack_error;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/i2cm_core.sv
// ----------------------------------------------------------------------------
// i2cm_core
// Bus sequencer: holds the engine state and works one tick request per step,
// producing the pin levels and flags that the tick leaves behind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire i2cm_pkg::req_t req,
  input  wire logic [7:0]    ticks_per_us,
  input  wire logic [7:0]    ack_timeout,
  output i2cm_pkg::res_t     res
);

  i2cm_pkg::eng_state_t st;
  i2cm_pkg::eng_state_t st_next;
  logic                 done;
  logic [7:0]           tick_us;
  logic [9:0]           d1;
  logic [9:0]           d2;
  logic [9:0]           d4;

  // Delay loads of 1, 2 and 4 us; a zero tick count counts as one
  assign tick_us = (ticks_per_us == 8'd0) ? 8'd1 : ticks_per_us;
  assign d1      = {2'b00, tick_us};
  assign d2      = {1'b0, tick_us, 1'b0};
  assign d4      = {tick_us, 2'b00};

  // Work out the state after this tick
  always_comb begin
    st_next = st;
    done    = 1'b0;
    if (st.phase == i2cm_pkg::PH_IDLE) begin
      if (req.cmd_valid) begin
        unique case (req.req_type)
          i2cm_pkg::REQ_START: begin
            st_next.sda_drive   = 1'b1;
            st_next.sda         = 1'b1;
            st_next.scl         = 1'b1;
            st_next.phase       = i2cm_pkg::PH_ST_A;
            st_next.delay_count = d4;
          end
          i2cm_pkg::REQ_STOP: begin
            st_next.sda_drive   = 1'b1;
            st_next.sda         = 1'b0;
            st_next.phase       = i2cm_pkg::PH_SP_A;
            st_next.delay_count = d4;
          end
          i2cm_pkg::REQ_WRITE: begin
            st_next.scl         = 1'b0;
            st_next.sda_drive   = 1'b1;
            st_next.sda         = req.tx_byte[7];
            st_next.shift_reg   = {req.tx_byte[6:0], 1'b0};
            st_next.bit_count   = 4'd1;
            st_next.phase       = i2cm_pkg::PH_WR_SET;
            st_next.delay_count = d2;
          end
          i2cm_pkg::REQ_WAIT: begin
            st_next.error_flag  = 1'b0;
            st_next.poll_count  = 8'd0;
            st_next.sda_drive   = 1'b0;
            st_next.sda         = 1'b1;
            st_next.phase       = i2cm_pkg::PH_WA_REL;
            st_next.delay_count = d1;
          end
          i2cm_pkg::REQ_READ: begin
            st_next.scl         = 1'b0;
            st_next.sda_drive   = 1'b0;
            st_next.sda         = 1'b1;
            st_next.bit_count   = 4'd0;
            st_next.shift_reg   = 8'd0;
            st_next.ack_latch   = req.send_ack;
            st_next.phase       = i2cm_pkg::PH_RD_LO;
            st_next.delay_count = d2;
          end
          default: begin
          end
        endcase
      end
    end else if (st.phase == i2cm_pkg::PH_WA_POLL) begin
      // Poll for acknowledge; give up with a stop after the allowed polls
      if (!req.sda_level) begin
        st_next.scl   = 1'b0;
        st_next.phase = i2cm_pkg::PH_IDLE;
        done          = 1'b1;
      end else if (st.poll_count >= ack_timeout) begin
        st_next.error_flag  = 1'b1;
        st_next.sda_drive   = 1'b1;
        st_next.sda         = 1'b0;
        st_next.phase       = i2cm_pkg::PH_SP_A;
        st_next.delay_count = d4;
      end else begin
        st_next.poll_count = st.poll_count + 8'd1;
      end
    end else if (st.delay_count > 10'd1) begin
      st_next.delay_count = st.delay_count - 10'd1;
    end else begin
      // Delay expired: advance the sequence
      st_next.delay_count = 10'd0;
      unique case (st.phase)
        i2cm_pkg::PH_RD_LO: begin
          st_next.scl         = 1'b1;
          st_next.shift_reg   = {st.shift_reg[6:0], req.sda_level};
          st_next.bit_count   = st.bit_count + 4'd1;
          st_next.phase       = i2cm_pkg::PH_RD_HI;
          st_next.delay_count = d1;
        end
        i2cm_pkg::PH_ST_A: begin
          st_next.sda_drive   = 1'b1;
          st_next.sda         = 1'b0;
          st_next.phase       = i2cm_pkg::PH_ST_B;
          st_next.delay_count = d4;
        end
        i2cm_pkg::PH_ST_B: begin
          st_next.scl   = 1'b0;
          st_next.phase = i2cm_pkg::PH_IDLE;
          done          = 1'b1;
        end
        i2cm_pkg::PH_SP_A: begin
          st_next.scl         = 1'b1;
          st_next.phase       = i2cm_pkg::PH_SP_B;
          st_next.delay_count = d4;
        end
        i2cm_pkg::PH_SP_B: begin
          st_next.sda_drive   = 1'b1;
          st_next.sda         = 1'b1;
          st_next.phase       = i2cm_pkg::PH_SP_C;
          st_next.delay_count = d4;
        end
        i2cm_pkg::PH_SP_C: begin
          st_next.phase = i2cm_pkg::PH_IDLE;
          done          = 1'b1;
        end
        i2cm_pkg::PH_WR_SET: begin
          st_next.scl         = 1'b1;
          st_next.phase       = i2cm_pkg::PH_WR_HI;
          st_next.delay_count = d2;
        end
        i2cm_pkg::PH_WR_HI: begin
          st_next.scl         = 1'b0;
          st_next.phase       = i2cm_pkg::PH_WR_LO;
          st_next.delay_count = d2;
        end
        i2cm_pkg::PH_WR_LO: begin
          if (st.bit_count < i2cm_pkg::BYTE_BITS) begin
            st_next.scl         = 1'b0;
            st_next.sda_drive   = 1'b1;
            st_next.sda         = st.shift_reg[7];
            st_next.shift_reg   = {st.shift_reg[6:0], 1'b0};
            st_next.bit_count   = st.bit_count + 4'd1;
            st_next.phase       = i2cm_pkg::PH_WR_SET;
            st_next.delay_count = d2;
          end else begin
            st_next.phase = i2cm_pkg::PH_IDLE;
            done          = 1'b1;
          end
        end
        i2cm_pkg::PH_WA_REL: begin
          st_next.scl         = 1'b1;
          st_next.phase       = i2cm_pkg::PH_WA_HI;
          st_next.delay_count = d1;
        end
        i2cm_pkg::PH_WA_HI: begin
          st_next.phase       = i2cm_pkg::PH_WA_POLL;
          st_next.delay_count = 10'd0;
        end
        i2cm_pkg::PH_RD_HI: begin
          st_next.scl = 1'b0;
          if (st.bit_count < i2cm_pkg::BYTE_BITS) begin
            st_next.phase       = i2cm_pkg::PH_RD_LO;
            st_next.delay_count = d2;
          end else begin
            st_next.rx          = st.shift_reg;
            st_next.sda_drive   = 1'b1;
            st_next.sda         = ~st.ack_latch;
            st_next.phase       = i2cm_pkg::PH_AK_SET;
            st_next.delay_count = d2;
          end
        end
        i2cm_pkg::PH_AK_SET: begin
          st_next.scl         = 1'b1;
          st_next.phase       = i2cm_pkg::PH_AK_HI;
          st_next.delay_count = d2;
        end
        i2cm_pkg::PH_AK_HI: begin
          st_next.scl   = 1'b0;
          st_next.phase = i2cm_pkg::PH_IDLE;
          done          = 1'b1;
        end
        default: begin
          st_next.phase = i2cm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Hold the engine state; advance only on a step
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= i2cm_pkg::PH_IDLE;
      st.bit_count   <= 4'd0;
      st.shift_reg   <= 8'd0;
      st.delay_count <= 10'd0;
      st.poll_count  <= 8'd0;
      st.scl         <= 1'b1;
      st.sda         <= 1'b1;
      st.sda_drive   <= 1'b1;
      st.error_flag  <= 1'b0;
      st.ack_latch   <= 1'b0;
      st.rx          <= 8'd0;
    end else if (step) begin
      st <= st_next;
    end
  end

  // Result of this tick
  always_comb begin
    res.scl_out   = st_next.scl;
    res.sda_out   = st_next.sda;
    res.sda_drive = st_next.sda_drive;
    res.busy_res  = (st_next.phase != i2cm_pkg::PH_IDLE);
    res.done_res  = done;
    res.rx_byte   = st_next.rx;
    res.ack_error = st_next.error_flag;
  end

endmodule

`default_nettype wire

FILE: rtl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: one request per clock tick carries a pin sample and
// an optional command; each request gives one result with pin levels, flags
// and the last received byte.
// ----------------------------------------------------------------------------
//  channel   signals                          moves
//  --------  -------------------------------  ------------------------------
//  in        in_valid, in_stall, in_data      one tick request (req_t)
//  out       out_valid, out_stall, out_data   one tick result (res_t)
//  cfg       cfg_wr_en, cfg_index, cfg_data   ticks_per_us, ack_timeout
//
//  A request is taken into an input register, worked by the sequencer and its
//  result lands in the output register: one request per cycle while the
//  output is not stalled. The rate is set by the sequencer, which works out
//  each next state combinationally.
//  rst is synchronous: engine idle, SCL and SDA high and driven, registers at
//  16 ticks per us and 250 polls.
//  A stalled output holds the result and stalls the input once the input
//  register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire i2cm_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output i2cm_pkg::res_t      out_data,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_index,
  input  wire logic [7:0]     cfg_data
);

  logic           in_full;
  i2cm_pkg::req_t in_reg;
  logic           out_free;
  logic           step;
  logic [7:0]     ticks_per_us;
  logic [7:0]     ack_timeout;
  i2cm_pkg::res_t res;

  // Work the held request whenever the output register can take its result
  assign out_free = !out_valid || !out_stall;
  assign step     = in_full && out_free;
  assign in_stall = in_full && !out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_us <= i2cm_pkg::TICKS_PER_US_RST;
      ack_timeout  <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_TICKS_PER_US: ticks_per_us <= cfg_data;
        i2cm_pkg::CFG_ACK_TIMEOUT:  ack_timeout  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Input register: take a request when empty or being drained
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg <= in_data;
    end
  end

  i2cm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .req          (in_reg),
    .ticks_per_us (ticks_per_us),
    .ack_timeout  (ack_timeout),
    .res          (res)
  );

  // Output register: load on a step, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire
